// ===== rtl/ifsd_pkg.sv =====
// Package with shared types and constants of the IPC frame stream deframer.
`timescale 1ns / 1ps
`default_nettype none

package ifsd_pkg;

    localparam int HDR_BYTES = 32;
    localparam int HDR_BITS  = HDR_BYTES * 8;
    localparam int CNT_W     = $clog2(HDR_BYTES);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [15:0] HDR_LEN_VALUE = 16'(HDR_BYTES);

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_TYPE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RSP_TYPE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EVT_TYPE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CODEC    = 3'd6;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [3:0] ERR_MAGIC     = 4'd0;
    localparam logic [3:0] ERR_VERSION   = 4'd1;
    localparam logic [3:0] ERR_HDR_LEN   = 4'd2;
    localparam logic [3:0] ERR_BODY_LEN  = 4'd3;
    localparam logic [3:0] ERR_TYPE      = 4'd4;
    localparam logic [3:0] ERR_CODEC     = 4'd5;
    localparam logic [3:0] ERR_FLAGS     = 4'd6;
    localparam logic [3:0] ERR_RESERVED  = 4'd7;
    localparam logic [3:0] ERR_CRC       = 4'd8;
    localparam logic [3:0] ERR_EVENT_ID  = 4'd9;
    localparam logic [3:0] ERR_ZERO_ID   = 4'd10;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] protocol_version;
        logic [31:0] max_body_length;
        logic [7:0]  request_type_code;
        logic [7:0]  response_type_code;
        logic [7:0]  event_type_code;
        logic [7:0]  accepted_codec_code;
    } cfg_t;

    typedef struct packed {
        logic       pass;
        logic [3:0] err;
    } check_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  body_byte;
        logic        frame_last;
        logic [7:0]  frame_type;
        logic [7:0]  frame_codec;
        logic [63:0] frame_request_id;
        logic [31:0] frame_body_length;
        logic [3:0]  error_code;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/ifsd_if.sv =====
// Stream interfaces for the input byte channel and the result channel.
`timescale 1ns / 1ps
`default_nettype none

interface ifsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface ifsd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  body_byte;
    logic        frame_last;
    logic [7:0]  frame_type;
    logic [7:0]  frame_codec;
    logic [63:0] frame_request_id;
    logic [31:0] frame_body_length;
    logic [3:0]  error_code;

    modport source (output valid, output result_kind, output body_byte, output frame_last,
                    output frame_type, output frame_codec, output frame_request_id,
                    output frame_body_length, output error_code, input ready);
    modport sink (input valid, input result_kind, input body_byte, input frame_last,
                  input frame_type, input frame_codec, input frame_request_id,
                  input frame_body_length, input error_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/ifsd_config_regs.sv =====
// Configuration register file written through a plain write port.
`timescale 1ns / 1ps
`default_nettype none

module ifsd_config_regs
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ifsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ifsd_pkg::CFG_DAT_W-1:0]  cfg_data,
    output ifsd_pkg::cfg_t                       cfg
);

    ifsd_pkg::cfg_t cfg_reg;
    ifsd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                ifsd_pkg::CFG_MAGIC:    cfg_next.magic_word          = cfg_data;
                ifsd_pkg::CFG_VERSION:  cfg_next.protocol_version    = cfg_data[15:0];
                ifsd_pkg::CFG_MAX_BODY: cfg_next.max_body_length     = cfg_data;
                ifsd_pkg::CFG_REQ_TYPE: cfg_next.request_type_code   = cfg_data[7:0];
                ifsd_pkg::CFG_RSP_TYPE: cfg_next.response_type_code  = cfg_data[7:0];
                ifsd_pkg::CFG_EVT_TYPE: cfg_next.event_type_code     = cfg_data[7:0];
                ifsd_pkg::CFG_CODEC:    cfg_next.accepted_codec_code = cfg_data[7:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/ifsd_hdr_check.sv =====
// Header field checks in priority order, giving the first failed check.
`timescale 1ns / 1ps
`default_nettype none

module ifsd_hdr_check
(
    input  wire logic [ifsd_pkg::HDR_BITS-1:0] header,
    input  wire ifsd_pkg::cfg_t                cfg,
    output ifsd_pkg::check_t                   status
);

    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] hdr_len;
    logic [31:0] body_size;
    logic [7:0]  mtype;
    logic [7:0]  codec;
    logic [15:0] flags;
    logic [63:0] req_id;
    logic [31:0] reserved_word;
    logic [31:0] crc_word;
    logic        is_event;
    logic        type_known;

    assign magic         = header[31:0];
    assign version       = header[47:32];
    assign hdr_len       = header[63:48];
    assign body_size     = header[95:64];
    assign mtype         = header[103:96];
    assign codec         = header[111:104];
    assign flags         = header[127:112];
    assign req_id        = header[191:128];
    assign reserved_word = header[223:192];
    assign crc_word      = header[255:224];

    assign is_event   = (mtype == cfg.event_type_code);
    assign type_known = (mtype == cfg.request_type_code) ||
                        (mtype == cfg.response_type_code) || is_event;

    always_comb
    begin
        status.pass = 1'b0;
        status.err  = ifsd_pkg::ERR_MAGIC;
        if (magic != cfg.magic_word)
        begin
            status.err = ifsd_pkg::ERR_MAGIC;
        end
        else if (version != cfg.protocol_version)
        begin
            status.err = ifsd_pkg::ERR_VERSION;
        end
        else if (hdr_len != ifsd_pkg::HDR_LEN_VALUE)
        begin
            status.err = ifsd_pkg::ERR_HDR_LEN;
        end
        else if (body_size > cfg.max_body_length)
        begin
            status.err = ifsd_pkg::ERR_BODY_LEN;
        end
        else if (!type_known)
        begin
            status.err = ifsd_pkg::ERR_TYPE;
        end
        else if (codec != cfg.accepted_codec_code)
        begin
            status.err = ifsd_pkg::ERR_CODEC;
        end
        else if (flags != 16'd0)
        begin
            status.err = ifsd_pkg::ERR_FLAGS;
        end
        else if (reserved_word != 32'd0)
        begin
            status.err = ifsd_pkg::ERR_RESERVED;
        end
        else if (crc_word != 32'd0)
        begin
            status.err = ifsd_pkg::ERR_CRC;
        end
        else if (is_event && (req_id != 64'd0))
        begin
            status.err = ifsd_pkg::ERR_EVENT_ID;
        end
        else if (!is_event && (req_id == 64'd0))
        begin
            status.err = ifsd_pkg::ERR_ZERO_ID;
        end
        else
        begin
            status.pass = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ifsd_parser.sv =====
// Frame parser: header shift register, byte count and body length tracking.
`timescale 1ns / 1ps
`default_nettype none

module ifsd_parser
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic [7:0]                    data_byte,
    input  wire ifsd_pkg::cfg_t                cfg,
    output logic                               has_result,
    output ifsd_pkg::result_t                  result
);

    localparam int STORE_BITS = ifsd_pkg::HDR_BITS - 8;

    logic [STORE_BITS-1:0]          hdr_reg;
    logic [STORE_BITS-1:0]          hdr_next;
    logic [ifsd_pkg::CNT_W-1:0]     count_reg;
    logic [ifsd_pkg::CNT_W-1:0]     count_next;
    logic [31:0]                    remaining_reg;
    logic [31:0]                    remaining_next;
    logic [ifsd_pkg::HDR_BITS-1:0]  header;
    logic                           in_body;
    logic                           hdr_done;
    ifsd_pkg::check_t               status;

    // The completing byte joins the 31 stored bytes, so the header is checked on arrival.
    assign header   = {data_byte, hdr_reg};
    assign in_body  = (remaining_reg != 32'd0);
    assign hdr_done = (count_reg == ifsd_pkg::CNT_W'(ifsd_pkg::HDR_BYTES - 1));

    ifsd_hdr_check u_check
    (
        .header (header),
        .cfg    (cfg),
        .status (status)
    );

    always_comb
    begin
        hdr_next       = hdr_reg;
        count_next     = count_reg;
        remaining_next = remaining_reg;
        has_result     = 1'b0;
        result         = '0;
        if (in_body)
        begin
            remaining_next    = remaining_reg - 32'd1;
            has_result        = 1'b1;
            result.result_kind = ifsd_pkg::KIND_BODY;
            result.body_byte   = data_byte;
            result.frame_last  = (remaining_reg == 32'd1);
        end
        else
        begin
            hdr_next   = {data_byte, hdr_reg[STORE_BITS-1:8]};
            count_next = count_reg + 1'b1;
            if (hdr_done)
            begin
                has_result = 1'b1;
                if (status.pass)
                begin
                    remaining_next           = header[95:64];
                    result.result_kind       = ifsd_pkg::KIND_HEADER;
                    result.frame_last        = (header[95:64] == 32'd0);
                    result.frame_type        = header[103:96];
                    result.frame_codec       = header[111:104];
                    result.frame_request_id  = header[191:128];
                    result.frame_body_length = header[95:64];
                end
                else
                begin
                    result.result_kind = ifsd_pkg::KIND_REJECT;
                    result.frame_last  = 1'b1;
                    result.error_code  = status.err;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            hdr_reg <= hdr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            remaining_reg <= '0;
        end
        else if (step)
        begin
            count_reg     <= count_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ipc_frame_stream_deframer_unit.sv =====
// Top level of the IPC frame stream deframer with input and result registers.
// An accepted byte is held in the input register, parsed from there, and any result is
// registered in the result register, where it is valid on the port. Throughput is one
// byte per cycle while results.ready lets the result register advance.
// Reset: rst_n clears the configuration registers, byte count, body length and valid flags.
`timescale 1ns / 1ps
`default_nettype none

module ipc_frame_stream_deframer_unit
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    ifsd_byte_if.sink                            bytes,
    ifsd_result_if.source                        results,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ifsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ifsd_pkg::CFG_DAT_W-1:0]  cfg_data
);

    ifsd_pkg::cfg_t    cfg;
    ifsd_pkg::result_t result;
    ifsd_pkg::result_t result_reg;
    logic              has_result;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [7:0]        byte_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              advance;
    logic              step;
    logic              accept;

    assign advance     = !out_valid_reg || results.ready;
    assign bytes.ready = !in_valid_reg || advance;
    assign accept      = bytes.valid && bytes.ready;
    assign step        = in_valid_reg && advance;

    ifsd_config_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ifsd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (byte_reg),
        .cfg        (cfg),
        .has_result (has_result),
        .result     (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = step && has_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= bytes.in_byte;
        end
        if (step && has_result)
        begin
            result_reg <= result;
        end
    end

    assign results.valid             = out_valid_reg;
    assign results.result_kind       = result_reg.result_kind;
    assign results.body_byte         = result_reg.body_byte;
    assign results.frame_last        = result_reg.frame_last;
    assign results.frame_type        = result_reg.frame_type;
    assign results.frame_codec       = result_reg.frame_codec;
    assign results.frame_request_id  = result_reg.frame_request_id;
    assign results.frame_body_length = result_reg.frame_body_length;
    assign results.error_code        = result_reg.error_code;

endmodule

`default_nettype wire
